@@ hw/rtl/wcr_pkg.sv @@
// wcr_pkg: types, constants and command/status structs of the word censor block
// used by wcr_ctrl, wcr_dp, the top level and the bench; depends on nothing
`default_nettype none
package wcr_pkg;

    localparam int RULE_COUNT = 4;
    localparam int WORD_MAX   = 16;
    localparam int REPL_MAX   = 16;
    localparam int SLOT       = 16;

    localparam int RULE_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int SLOT_W = $clog2(SLOT);
    localparam int ADDR_W = RULE_W + SLOT_W;
    localparam int MEM_DEPTH = RULE_COUNT * SLOT;
    localparam int CNT_W = $clog2(WORD_MAX + 1);
    localparam int IDX_W = $clog2(WORD_MAX);
    localparam int LEN_CAP0 = (SLOT < REPL_MAX) ? SLOT : REPL_MAX;
    localparam int LEN_CAP  = (LEN_CAP0 < WORD_MAX) ? LEN_CAP0 : WORD_MAX;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [1:0] OP_TEXT   = 2'd0;
    localparam logic [1:0] OP_PAT    = 2'd1;
    localparam logic [1:0] OP_REPL   = 2'd2;
    localparam logic [1:0] OP_HEADER = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_in;
        logic [1:0] rule_index;
        logic [3:0] position;
        logic       rule_valid;
        logic       rule_mode;
        logic [4:0] pattern_length;
        logic [4:0] replacement_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic       mode;
        logic [4:0] plen;
        logic [4:0] rlen;
    } t_hdr;

    typedef enum logic [1:0] {
        SRC_BUF = 2'd0,
        SRC_CH  = 2'd1,
        SRC_SP  = 2'd2,
        SRC_NL  = 2'd3
    } t_src;

    typedef struct packed {
        logic accept;
        logic store;
        logic flush_set;
        logic rule_clr;
        logic rule_inc;
        logic idx_clr;
        logic idx_inc;
        logic rd_pat;
        logic rd_rep;
        logic mask;
        logic repl_len;
        logic copy_wr;
        logic clr_word;
        logic set_ovf;
        logic emit;
        t_src src;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic is_delim;
        logic ovf;
        logic full;
        logic eligible;
        logic byte_eq;
        logic idx_pat_last;
        logic mode;
        logic repl_zero;
        logic idx_cnt_last;
        logic rule_last;
        logic idx_at_cnt;
        logic flush;
        logic nl;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ hw/rtl/wcr_ram.sv @@
// wcr_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module wcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/wcr_dp.sv @@
// wcr_dp: datapath with rule tables, word buffer, counters and output register
// depends on wcr_pkg and wcr_ram
`default_nettype none
module wcr_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wcr_pkg::t_in_item i_in_item,
    input  wire logic              i_out_stall,
    input  wire wcr_pkg::t_cmd     i_cmd,
    output wcr_pkg::t_status       o_status,
    output logic                   o_out_valid,
    output wcr_pkg::t_out_item     o_out_item
);
    localparam int RW = wcr_pkg::RULE_W;
    localparam int AW = wcr_pkg::ADDR_W;
    localparam int CW = wcr_pkg::CNT_W;
    localparam int IW = wcr_pkg::IDX_W;

    wcr_pkg::t_hdr r_hdr [wcr_pkg::RULE_COUNT];
    logic [7:0]    r_buf [wcr_pkg::WORD_MAX];
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_flush;
    logic [RW-1:0] r_rule;
    logic [CW-1:0] r_idx;
    logic [7:0]    r_ch;
    logic          r_nl;
    logic          r_oval;
    wcr_pkg::t_out_item r_oitem;

    logic [7:0]    pat_q;
    logic [7:0]    rep_q;
    logic          load_ok;
    logic          we_pat;
    logic          we_rep;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    wcr_pkg::t_hdr cur;
    logic [CW-1:0] rep_len;
    logic [7:0]    buf_rd;
    logic          out_free;
    logic [7:0]    n_char;

    assign load_ok = ({1'b0, i_in_item.rule_index} < 3'(wcr_pkg::RULE_COUNT));
    assign we_pat  = i_cmd.accept && load_ok && (i_in_item.operation == wcr_pkg::OP_PAT);
    assign we_rep  = i_cmd.accept && load_ok && (i_in_item.operation == wcr_pkg::OP_REPL);
    assign waddr   = {i_in_item.rule_index[RW-1:0], i_in_item.position[wcr_pkg::SLOT_W-1:0]};
    assign raddr   = {r_rule, r_idx[wcr_pkg::SLOT_W-1:0]};
    assign cur     = r_hdr[r_rule];
    assign rep_len = (int'(cur.rlen) > wcr_pkg::LEN_CAP) ? CW'(wcr_pkg::LEN_CAP)
                                                          : CW'(cur.rlen);
    assign buf_rd  = r_buf[r_idx[IW-1:0]];
    assign out_free = !r_oval || !i_out_stall;

    wcr_ram #(.WIDTH(8), .DEPTH(wcr_pkg::MEM_DEPTH)) u_pat (
        .i_clk  (i_clk),
        .i_we   (we_pat),
        .i_waddr(waddr),
        .i_wdata(i_in_item.char_in),
        .i_re   (i_cmd.rd_pat),
        .i_raddr(raddr),
        .o_rdata(pat_q)
    );

    wcr_ram #(.WIDTH(8), .DEPTH(wcr_pkg::MEM_DEPTH)) u_rep (
        .i_clk  (i_clk),
        .i_we   (we_rep),
        .i_waddr(waddr),
        .i_wdata(i_in_item.char_in),
        .i_re   (i_cmd.rd_rep),
        .i_raddr(raddr),
        .o_rdata(rep_q)
    );

    always_comb begin
        o_status.is_load  = (i_in_item.operation != wcr_pkg::OP_TEXT);
        o_status.is_delim = (i_in_item.char_in == wcr_pkg::CH_SPACE)
                         || (i_in_item.char_in == wcr_pkg::CH_NL);
        o_status.ovf      = r_ovf;
        o_status.full     = (int'(r_count) >= wcr_pkg::WORD_MAX);
        o_status.eligible = cur.valid && (cur.plen != 5'd0)
                         && (int'(cur.plen) <= wcr_pkg::SLOT)
                         && (int'(cur.plen) <= wcr_pkg::WORD_MAX)
                         && (int'(cur.plen) == int'(r_count));
        o_status.byte_eq      = (pat_q == buf_rd);
        o_status.idx_pat_last = (int'(r_idx) + 1 == int'(cur.plen));
        o_status.mode         = cur.mode;
        o_status.repl_zero    = (rep_len == '0);
        o_status.idx_cnt_last = (int'(r_idx) + 1 == int'(r_count));
        o_status.rule_last    = (int'(r_rule) == wcr_pkg::RULE_COUNT - 1);
        o_status.idx_at_cnt   = (r_idx == r_count);
        o_status.flush        = r_flush;
        o_status.nl           = r_nl;
        o_status.out_free     = out_free;
    end

    always_comb begin
        case (i_cmd.src)
            wcr_pkg::SRC_BUF: n_char = buf_rd;
            wcr_pkg::SRC_CH:  n_char = r_ch;
            wcr_pkg::SRC_SP:  n_char = wcr_pkg::CH_SPACE;
            wcr_pkg::SRC_NL:  n_char = wcr_pkg::CH_NL;
            default:          n_char = wcr_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ch <= i_in_item.char_in;
            r_nl <= (i_in_item.char_in == wcr_pkg::CH_NL);
        end
        if (i_cmd.store) begin
            r_buf[r_count[IW-1:0]] <= i_in_item.char_in;
        end
        if (i_cmd.mask) begin
            for (int k = 0; k < wcr_pkg::WORD_MAX; k++) begin
                r_buf[k] <= wcr_pkg::CH_STAR;
            end
        end
        if (i_cmd.copy_wr) begin
            r_buf[r_idx[IW-1:0]] <= rep_q;
        end
        if (i_cmd.emit) begin
            r_oitem.char_out <= n_char;
            r_oitem.last     <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wcr_pkg::RULE_COUNT; k++) begin
                r_hdr[k] <= '0;
            end
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_flush <= 1'b0;
            r_rule  <= '0;
            r_idx   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cmd.accept && load_ok && (i_in_item.operation == wcr_pkg::OP_HEADER)) begin
                r_hdr[i_in_item.rule_index[RW-1:0]] <= '{
                    valid: i_in_item.rule_valid,
                    mode:  i_in_item.rule_mode,
                    plen:  i_in_item.pattern_length,
                    rlen:  i_in_item.replacement_length
                };
            end
            if (i_cmd.store) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.repl_len) begin
                r_count <= rep_len;
            end
            if (i_cmd.clr_word) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_flush <= 1'b0;
            end
            if (i_cmd.set_ovf) begin
                r_count <= '0;
                r_ovf   <= 1'b1;
                r_flush <= 1'b0;
            end
            if (i_cmd.flush_set) begin
                r_flush <= 1'b1;
            end
            if (i_cmd.rule_clr) begin
                r_rule <= '0;
            end else if (i_cmd.rule_inc) begin
                r_rule <= r_rule + 1'b1;
            end
            if (i_cmd.idx_clr || i_cmd.repl_len) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_oval <= 1'b1;
            end else if (!i_out_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_oval;
    assign o_out_item  = r_oitem;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= wcr_pkg::WORD_MAX)
        else $error("word count beyond buffer");
    a_ovf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == '0))
        else $error("overflow with buffered bytes");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("emit into a held output item");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/wcr_ctrl.sv @@
// wcr_ctrl: sequencer for rule matching, rewriting and byte output
// depends on wcr_pkg
`default_nettype none
module wcr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire wcr_pkg::t_status i_status,
    output logic                  o_in_stall,
    output wcr_pkg::t_cmd         o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RULE  = 12'b000000000010,
        S_CRD   = 12'b000000000100,
        S_CCK   = 12'b000000001000,
        S_APPLY = 12'b000000010000,
        S_RRD   = 12'b000000100000,
        S_RWR   = 12'b000001000000,
        S_NEXT  = 12'b000010000000,
        S_EMBUF = 12'b000100000000,
        S_EMCH  = 12'b001000000000,
        S_EMSP  = 12'b010000000000,
        S_EMNL  = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_status.is_load) begin
                        if (i_status.is_delim) begin
                            if (i_status.ovf) begin
                                n_state = S_EMSP;
                            end else begin
                                o_cmd.rule_clr = 1'b1;
                                n_state = S_RULE;
                            end
                        end else if (i_status.ovf) begin
                            n_state = S_EMCH;
                        end else if (i_status.full) begin
                            o_cmd.idx_clr   = 1'b1;
                            o_cmd.flush_set = 1'b1;
                            n_state = S_EMBUF;
                        end else begin
                            o_cmd.store = 1'b1;
                        end
                    end
                end
            end
            S_RULE: begin
                if (i_status.eligible) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_CRD;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_CRD: begin
                o_cmd.rd_pat = 1'b1;
                n_state = S_CCK;
            end
            S_CCK: begin
                if (!i_status.byte_eq) begin
                    n_state = S_NEXT;
                end else if (i_status.idx_pat_last) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_CRD;
                end
            end
            S_APPLY: begin
                if (!i_status.mode) begin
                    o_cmd.mask = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    o_cmd.repl_len = 1'b1;
                    n_state = i_status.repl_zero ? S_NEXT : S_RRD;
                end
            end
            S_RRD: begin
                o_cmd.rd_rep = 1'b1;
                n_state = S_RWR;
            end
            S_RWR: begin
                o_cmd.copy_wr = 1'b1;
                if (i_status.idx_cnt_last) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_RRD;
                end
            end
            S_NEXT: begin
                if (i_status.rule_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_EMBUF;
                end else begin
                    o_cmd.rule_inc = 1'b1;
                    n_state = S_RULE;
                end
            end
            S_EMBUF: begin
                if (i_status.idx_at_cnt) begin
                    if (i_status.flush) begin
                        o_cmd.set_ovf = 1'b1;
                        n_state = S_EMCH;
                    end else begin
                        n_state = S_EMSP;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.src     = wcr_pkg::SRC_BUF;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EMCH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = wcr_pkg::SRC_CH;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMSP: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.src      = wcr_pkg::SRC_SP;
                    o_cmd.last     = !i_status.nl;
                    o_cmd.clr_word = 1'b1;
                    n_state = i_status.nl ? S_EMNL : S_IDLE;
                end
            end
            S_EMNL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = wcr_pkg::SRC_NL;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.src == wcr_pkg::SRC_BUF) |-> !o_cmd.last)
        else $error("word byte marked last");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state != S_IDLE) || !$past(o_cmd.emit))
        else $error("accept while emitting");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rd_pat, o_cmd.rd_rep, o_cmd.mask, o_cmd.copy_wr}))
        else $error("conflicting datapath commands");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/word_censor_replace_stream_core.sv @@
// word_censor_replace_stream_core: top level of the word censor and replace block
// depends on wcr_pkg, wcr_ctrl, wcr_dp and wcr_ram
//
// input channel (i_in_valid / o_in_stall, payload i_in_item): text bytes and
// pattern, replacement and rule header loads; loads give no output item
// output channel (o_out_valid / i_out_stall, payload o_out_item): text bytes,
// last set on the final item caused by one input item
// one item is taken while the sequencer is idle; a text byte that is stored
// in the word produces nothing
// on a space or newline after a word that did not overflow, the sequencer
// visits each rule in turn: it checks the header, compares the pattern with
// the word byte by byte, then masks the word or sets its new length and copies
// the replacement bytes; then it emits the word bytes, a space and, for a
// newline, a newline too; the loops read each byte from the shared pattern or
// replacement memory, then compare it with or write it into the word buffer
// a stalled receiver holds the output register and the sequencer waits
// reset clears the rule headers (all rules disabled), the word and overflow
// state; pattern and replacement memories hold nothing until loaded
`default_nettype none
module word_censor_replace_stream_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire wcr_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output wcr_pkg::t_out_item      o_out_item
);
    wcr_pkg::t_cmd    cmd;
    wcr_pkg::t_status status;

    wcr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    wcr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_out_stall(i_out_stall),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item)
    );
endmodule
`default_nettype wire

@@ test/word_censor_replace_stream_core_test.sv @@
// word_censor_replace_stream_core_test: self-checking bench for the word censor block
// depends on wcr_pkg and word_censor_replace_stream_core; predicts output bytes per item
module word_censor_replace_stream_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wcr_pkg::*;

    class censor_board;
        logic [7:0] pat_mem [MEM_DEPTH];
        logic [7:0] rep_mem [MEM_DEPTH];
        t_hdr       hdr [RULE_COUNT];
        logic [7:0] word [WORD_MAX];
        int         word_len;
        bit         overflow;
        t_out_item  pending [$];
        int         errors;

        function new();
            foreach (hdr[r]) hdr[r] = '0;
            word_len = 0;
            overflow = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void push_byte(logic [7:0] ch);
            t_out_item o;
            o.char_out = ch;
            o.last = 1'b0;
            pending.push_back(o);
        endfunction

        function bit rule_hit(int r);
            int n;
            n = hdr[r].plen;
            if (n == 0 || n > SLOT || n > WORD_MAX || n != word_len) return 0;
            for (int i = 0; i < n; i++)
                if (word[i] != pat_mem[r*SLOT+i]) return 0;
            return 1;
        endfunction

        function void rewrite_word();
            int n;
            for (int r = 0; r < RULE_COUNT; r++) begin
                if (!hdr[r].valid || !rule_hit(r)) continue;
                if (!hdr[r].mode) begin
                    for (int i = 0; i < word_len; i++) word[i] = CH_STAR;
                end else begin
                    n = hdr[r].rlen;
                    if (n > LEN_CAP) n = LEN_CAP;
                    for (int i = 0; i < n; i++) word[i] = rep_mem[r*SLOT+i];
                    word_len = n;
                end
            end
        endfunction

        function void note_input(t_in_item it);
            int before_n;
            before_n = pending.size();
            case (it.operation)
                OP_PAT:    pat_mem[it.rule_index*SLOT+it.position] = it.char_in;
                OP_REPL:   rep_mem[it.rule_index*SLOT+it.position] = it.char_in;
                OP_HEADER: begin
                    hdr[it.rule_index].valid = it.rule_valid;
                    hdr[it.rule_index].mode  = it.rule_mode;
                    hdr[it.rule_index].plen  = it.pattern_length;
                    hdr[it.rule_index].rlen  = it.replacement_length;
                end
                default: begin
                    if (it.char_in == CH_SPACE || it.char_in == CH_NL) begin
                        if (!overflow) begin
                            rewrite_word();
                            for (int i = 0; i < word_len; i++) push_byte(word[i]);
                        end
                        push_byte(CH_SPACE);
                        if (it.char_in == CH_NL) push_byte(CH_NL);
                        word_len = 0;
                        overflow = 0;
                    end else if (overflow) begin
                        push_byte(it.char_in);
                    end else if (word_len >= WORD_MAX) begin
                        for (int i = 0; i < WORD_MAX; i++) push_byte(word[i]);
                        push_byte(it.char_in);
                        word_len = 0;
                        overflow = 1;
                    end else begin
                        word[word_len] = it.char_in;
                        word_len++;
                    end
                end
            endcase
            if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
        endfunction

        task check_output(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected item char %h last %b", got.char_out, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.char_out !== want.char_out)
                report($sformatf("char_out %h, want %h", got.char_out, want.char_out));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;

    censor_board board;
    int  in_idle_pct;
    int  out_stall_pct;
    bit  hold_out;
    int  cycles;
    int  text_sent;

    word_censor_replace_stream_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 1500000) begin
                $display("timeout");
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= hold_out || ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        bit        took;
        t_out_item seen;
        forever begin
            @(negedge i_clk);
            took = i_rst_n && out_valid && !out_stall;
            seen = out_item;
            @(posedge i_clk);
            if (took) board.check_output(seen);
        end
    end

    task send(t_in_item it);
        bit stalled;
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        forever begin
            @(negedge i_clk);
            stalled = in_stall;
            @(posedge i_clk);
            if (!stalled) break;
        end
        board.note_input(it);
        if (it.operation == OP_TEXT) text_sent++;
    endtask

    task send_op(logic [1:0] op, logic [7:0] ch, logic [1:0] r, logic [3:0] pos);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'($urandom));
        it.operation  = op;
        it.char_in    = ch;
        it.rule_index = r;
        it.position   = pos;
        send(it);
    endtask

    task send_header(logic [1:0] r, bit v, bit m, logic [4:0] pl, logic [4:0] rl);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'($urandom));
        it.operation          = OP_HEADER;
        it.rule_index         = r;
        it.rule_valid         = v;
        it.rule_mode          = m;
        it.pattern_length     = pl;
        it.replacement_length = rl;
        send(it);
    endtask

    // all sixteen bytes are written so no rule ever reads an unloaded byte
    task load_rule(logic [1:0] r, string pat_s, string rep_s, bit v, bit m,
                   logic [4:0] pl, logic [4:0] rl);
        for (int i = 0; i < SLOT; i++)
            send_op(OP_PAT, (i < pat_s.len()) ? pat_s[i] : 8'($urandom), r, 4'(i));
        for (int i = 0; i < SLOT; i++)
            send_op(OP_REPL, (i < rep_s.len()) ? rep_s[i] : 8'($urandom), r, 4'(i));
        send_header(r, v, m, pl, rl);
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++) send_op(OP_TEXT, s[i], 2'($urandom), 4'($urandom));
    endtask

    function logic [7:0] word_byte(bit letters_only);
        logic [7:0] b;
        if (letters_only) return ($urandom_range(1)) ? "a" : "b";
        do b = 8'($urandom); while (b == CH_SPACE || b == CH_NL);
        return b;
    endfunction

    task random_step();
        int kind;
        int n;
        int r;
        kind = $urandom_range(99);
        if (kind < 4) begin
            r = $urandom_range(RULE_COUNT-1);
            if ($urandom_range(1))
                send_op(OP_PAT, word_byte($urandom_range(3) != 0), 2'(r), 4'($urandom));
            else
                send_op(OP_REPL, 8'($urandom), 2'(r), 4'($urandom));
        end else if (kind < 7) begin
            send_header(2'($urandom), $urandom_range(3) != 0, 1'($urandom),
                        ($urandom_range(5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)),
                        ($urandom_range(5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5)));
        end else if (kind < 15) begin
            send_op(OP_TEXT, 8'($urandom), 2'($urandom), 4'($urandom));
        end else begin
            r = $urandom_range(RULE_COUNT-1);
            if (kind < 55) begin
                n = board.hdr[r].plen;
                if (n > SLOT) n = SLOT;
                for (int i = 0; i < n; i++)
                    send_op(OP_TEXT, board.pat_mem[r*SLOT+i], 2'($urandom), 4'($urandom));
            end else begin
                n = ($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 5);
                for (int i = 0; i < n; i++)
                    send_op(OP_TEXT, word_byte(kind < 80), 2'($urandom), 4'($urandom));
            end
            send_op(OP_TEXT, ($urandom_range(3) == 0) ? CH_NL : CH_SPACE,
                    2'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        board = new();
        in_idle_pct = 0;
        out_stall_pct = 0;
        hold_out = 1'b0;
        text_sent = 0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        load_rule(2'd0, "ab", "", 1, 0, 5'd2, 5'd0);
        load_rule(2'd1, "**", "xyz", 1, 1, 5'd2, 5'd3);
        load_rule(2'd2, "cat", "", 1, 1, 5'd3, 5'd0);
        load_rule(2'd3, "zz", "0123456789abcdef", 0, 1, 5'd2, 5'd31);
        send_text("ab cat\n \nzz ");
        send_header(2'd3, 1, 1, 5'd2, 5'd31);
        send_text("zz qqqqqqqqqqqqqqqqqr\n");
        send_op(OP_TEXT, 8'h00, 2'd0, 4'd0);
        send_op(OP_TEXT, 8'hFF, 2'd0, 4'd0);
        send_text(" ");
        send_header(2'd0, 1, 0, 5'd0, 5'd0);
        send_header(2'd2, 1, 0, 5'd17, 5'd0);
        send_text("ab cat ");

        for (int ph = 0; ph < 4; ph++) begin
            in_idle_pct   = (ph == 1 || ph == 3) ? ((ph == 1) ? 69 : 29) : 0;
            out_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 69 : 29) : 0;
            if (ph == 0) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            while (text_sent < 44 + 30 * (ph + 1)) random_step();
        end

        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.pending.size() != 0)
            board.report($sformatf("%0d items never came", board.pending.size()));
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
